/* rtl/aawf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aawf_pkg
// Command codes and shared types for the accumulator ALU.
// ----------------------------------------------------------------------------
package aawf_pkg;

    localparam logic [3:0] CMD_LOAD_REG     = 4'd0;
    localparam logic [3:0] CMD_LOAD_ACC     = 4'd1;
    localparam logic [3:0] CMD_ACC_FROM_REG = 4'd2;
    localparam logic [3:0] CMD_ADD          = 4'd3;
    localparam logic [3:0] CMD_ADC          = 4'd4;
    localparam logic [3:0] CMD_SUB          = 4'd5;
    localparam logic [3:0] CMD_SBB          = 4'd6;
    localparam logic [3:0] CMD_AND          = 4'd7;
    localparam logic [3:0] CMD_OR           = 4'd8;
    localparam logic [3:0] CMD_XOR          = 4'd9;
    localparam logic [3:0] CMD_CMP          = 4'd10;
    localparam logic [3:0] CMD_CMC          = 4'd11;
    localparam logic [3:0] CMD_STC          = 4'd12;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic cy;
    } t_flags;

    // ALU outcome for one request
    typedef struct packed {
        logic [7:0] acc;
        t_flags     flags;
    } t_alu_result;

endpackage

/* rtl/accumulator_alu_with_flags_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_unit
// 8-bit accumulator ALU with register file and S/Z/AC/P/CY flags.
// ----------------------------------------------------------------------------
// Usage: one request per cycle, back to back, while the result side does
// not stall. A request executes out of the input register and lands in
// the result register at the next edge, which raises result valid. The
// rate is set by the single-pass ALU stage: the accumulator and flags are
// updated in the same cycle the request executes, so the next request in
// the input register already sees them. Each request gives exactly one
// result. A request whose register index is out of range and that needs
// the register reports bad_register and changes no state. reg_value is
// the selected register after the request, zero for an invalid index.
// Both sides use valid/stall; o_in_stall rises only when a request waits
// in the input register behind a stalled result.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags_unit import aawf_pkg::*; #(
    parameter int NUM_REGS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request side
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_command,
    input  logic [2:0] i_reg_select,
    input  logic       i_use_operand,
    input  logic [7:0] i_operand,
    // result side
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_acc_value,
    output logic       o_flag_sign,
    output logic       o_flag_zero,
    output logic       o_flag_aux,
    output logic       o_flag_parity,
    output logic       o_flag_carry,
    output logic [7:0] o_reg_value,
    output logic       o_bad_register
);

    // input register
    logic       r_in_valid;
    logic [3:0] r_command;
    logic [2:0] r_reg_select;
    logic       r_use_operand;
    logic [7:0] r_operand;

    // architectural state
    logic [7:0] r_acc;
    t_flags     r_flags;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_acc;
    t_flags     r_out_flags;
    logic [7:0] r_out_reg;
    logic       r_out_bad;

    logic        w_fire;
    logic        w_in_accept;
    logic        w_needs_reg;
    logic        w_bad;
    logic        w_rd_valid;
    logic [7:0]  w_rd_data;
    logic        w_wr_en;
    logic [7:0]  n_reg_value;
    t_alu_result w_alu;

    // execute when the result register is free or being drained
    assign w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_needs_reg = (r_command == CMD_LOAD_REG) || (r_command == CMD_ACC_FROM_REG) ||
                         ((r_command inside {[CMD_ADD:CMD_CMP]}) && !r_use_operand);
    assign w_bad       = w_needs_reg && !w_rd_valid;
    assign w_wr_en     = w_fire && !w_bad && (r_command == CMD_LOAD_REG);
    // register readback reflects this request's write
    assign n_reg_value = (r_command == CMD_LOAD_REG && !w_bad) ? r_operand : w_rd_data;

    aawf_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_sel   (r_reg_select),
        .i_wr_data  (r_operand),
        .i_rd_sel   (r_reg_select),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    aawf_alu u_alu (
        .i_command     (r_command),
        .i_use_operand (r_use_operand),
        .i_operand     (r_operand),
        .i_reg_data    (w_rd_data),
        .i_acc         (r_acc),
        .i_flags       (r_flags),
        .o_result      (w_alu)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_command     <= i_command;
            r_reg_select  <= i_reg_select;
            r_use_operand <= i_use_operand;
            r_operand     <= i_operand;
        end
    end

    // accumulator and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 8'd0;
            r_flags <= '0;
        end else if (w_fire && !w_bad) begin
            r_acc   <= w_alu.acc;
            r_flags <= w_alu.flags;
        end
    end

    // result register; reported state is the state after the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_acc   <= w_bad ? r_acc : w_alu.acc;
            r_out_flags <= w_bad ? r_flags : w_alu.flags;
            r_out_reg   <= n_reg_value;
            r_out_bad   <= w_bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_acc_value    = r_out_acc;
    assign o_flag_sign    = r_out_flags.s;
    assign o_flag_zero    = r_out_flags.z;
    assign o_flag_aux     = r_out_flags.ac;
    assign o_flag_parity  = r_out_flags.p;
    assign o_flag_carry   = r_out_flags.cy;
    assign o_reg_value    = r_out_reg;
    assign o_bad_register = r_out_bad;

endmodule

/* rtl/aawf_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aawf_alu
// Single-pass 8-bit ALU: next accumulator and flags for one command.
// ----------------------------------------------------------------------------
module aawf_alu import aawf_pkg::*; (
    input  logic [3:0]  i_command,
    input  logic        i_use_operand,
    input  logic [7:0]  i_operand,
    input  logic [7:0]  i_reg_data,
    input  logic [7:0]  i_acc,
    input  t_flags      i_flags,
    output t_alu_result o_result
);

    logic [7:0] w_b;
    logic       w_cin;
    logic [8:0] w_sum;
    logic [4:0] w_sum_lo;
    logic [8:0] w_diff;
    logic [4:0] w_diff_lo;
    logic [7:0] w_logic;

    assign w_b   = i_use_operand ? i_operand : i_reg_data;
    assign w_cin = ((i_command == CMD_ADC) || (i_command == CMD_SBB)) ? i_flags.cy : 1'b0;

    assign w_sum     = {1'b0, i_acc} + {1'b0, w_b} + {8'd0, w_cin};
    assign w_sum_lo  = {1'b0, i_acc[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_cin};
    // bit 8 / bit 4 of the wrapped difference is the borrow
    assign w_diff    = {1'b0, i_acc} - {1'b0, w_b} - {8'd0, w_cin};
    assign w_diff_lo = {1'b0, i_acc[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_cin};

    always_comb begin
        case (i_command)
            CMD_AND: w_logic = i_acc & w_b;
            CMD_OR:  w_logic = i_acc | w_b;
            default: w_logic = i_acc ^ w_b;
        endcase
    end

    function automatic t_flags szp(input logic [7:0] r, input logic ac, input logic cy);
        t_flags f;
        f.s  = r[7];
        f.z  = (r == 8'd0);
        f.ac = ac;
        f.p  = ~(^r);
        f.cy = cy;
        return f;
    endfunction

    always_comb begin
        o_result.acc   = i_acc;
        o_result.flags = i_flags;
        unique case (i_command) inside
            CMD_LOAD_ACC: begin
                o_result.acc = i_operand;
            end
            CMD_ACC_FROM_REG: begin
                o_result.acc = i_reg_data;
            end
            CMD_ADD, CMD_ADC: begin
                o_result.acc   = w_sum[7:0];
                o_result.flags = szp(w_sum[7:0], w_sum_lo[4], w_sum[8]);
            end
            CMD_SUB, CMD_SBB: begin
                o_result.acc   = w_diff[7:0];
                o_result.flags = szp(w_diff[7:0], w_diff_lo[4], w_diff[8]);
            end
            CMD_CMP: begin
                o_result.flags = szp(w_diff[7:0], w_diff_lo[4], w_diff[8]);
            end
            CMD_AND, CMD_OR, CMD_XOR: begin
                o_result.acc   = w_logic;
                o_result.flags = szp(w_logic, 1'b0, 1'b0);
            end
            CMD_CMC: begin
                o_result.flags.cy = ~i_flags.cy;
            end
            CMD_STC: begin
                o_result.flags.cy = 1'b1;
            end
            default: begin
                // load reg and unused codes leave acc and flags alone
            end
        endcase
    end

endmodule

/* rtl/aawf_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aawf_regfile
// Small register file, one write and one read port, cleared by reset.
// ----------------------------------------------------------------------------
module aawf_regfile #(
    parameter int NUM_REGS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  logic [2:0] i_wr_sel,
    input  logic [7:0] i_wr_data,
    input  logic [2:0] i_rd_sel,
    output logic [7:0] o_rd_data,
    output logic       o_rd_valid
);

    localparam int SEL_W = $clog2(NUM_REGS);

    logic [7:0] r_regs [NUM_REGS];
    logic       w_wr_valid;

    assign w_wr_valid = (32'(i_wr_sel) < NUM_REGS);
    assign o_rd_valid = (32'(i_rd_sel) < NUM_REGS);
    // invalid index reads as zero
    assign o_rd_data  = o_rd_valid ? r_regs[i_rd_sel[SEL_W-1:0]] : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
        end else if (i_wr_en && w_wr_valid) begin
            r_regs[i_wr_sel[SEL_W-1:0]] <= i_wr_data;
        end
    end

endmodule

/* rtl/aawf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aawf_checker
// Port-level checks for the accumulator ALU, bound to the top level.
// ----------------------------------------------------------------------------
module aawf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_acc_value,
    input logic       o_flag_sign,
    input logic       o_flag_zero,
    input logic       o_flag_parity,
    input logic [7:0] o_reg_value,
    input logic       o_bad_register
);

    logic [7:0] r_last_acc;
    logic       w_out_accept;

    assign w_out_accept = o_out_valid && !i_out_stall;

    // accumulator of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_acc <= 8'd0;
        end else if (w_out_accept) begin
            r_last_acc <= o_acc_value;
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_acc_value) && $stable(o_reg_value))
        else $error("stalled result changed");

    a_bad_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_accept && o_bad_register |-> o_acc_value == r_last_acc)
        else $error("bad register request changed the accumulator");

    a_bad_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_register |-> o_reg_value == 8'd0)
        else $error("bad register reported nonzero register value");

    a_zero_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_flag_zero |-> o_flag_parity && !o_flag_sign)
        else $error("zero flag inconsistent with sign or parity");

endmodule

bind accumulator_alu_with_flags_unit aawf_checker u_aawf_checker (.*);

/* tb/aawf_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aawf_result_checker
// Watches both channels of the accumulator ALU, predicts each result from
// its own copy of accumulator, register file and flags, and compares.
// ----------------------------------------------------------------------------
module aawf_result_checker import aawf_pkg::*; #(
    parameter int NUM_REGS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [3:0] i_command,
    input  logic [2:0] i_reg_select,
    input  logic       i_use_operand,
    input  logic [7:0] i_operand,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_acc_value,
    input  logic       i_flag_sign,
    input  logic       i_flag_zero,
    input  logic       i_flag_aux,
    input  logic       i_flag_parity,
    input  logic       i_flag_carry,
    input  logic [7:0] i_reg_value,
    input  logic       i_bad_register,
    output int         o_mismatches,
    output int         o_outstanding,
    output int         o_results_checked,
    output int         o_bad_reg_results
);

    typedef struct packed {
        logic [7:0] acc;
        t_flags     flags;
        logic [7:0] reg_value;
        logic       bad;
    } t_alu_outcome;

    logic [7:0]   acc_model;
    logic [7:0]   regfile_model [8];
    t_flags       flags_model;
    t_alu_outcome outcome_q [$];

    int mismatches;
    int outstanding;
    int results_checked;
    int bad_reg_results;

    assign o_mismatches      = mismatches;
    assign o_outstanding     = outstanding;
    assign o_results_checked = results_checked;
    assign o_bad_reg_results = bad_reg_results;

    function automatic t_flags szp_flags(input logic [7:0] r);
        t_flags f;
        f    = '0;
        f.s  = r[7];
        f.z  = (r == 8'h00);
        f.p  = ~^r;
        return f;
    endfunction

    // Run one request on the model state; returns what the block must report.
    task automatic apply_instruction(
        input  logic [3:0]   cmd,
        input  logic [2:0]   sel,
        input  logic         use_op,
        input  logic [7:0]   opnd,
        output t_alu_outcome res
    );
        logic       sel_ok;
        logic       needs_reg;
        logic       bad;
        logic [7:0] a;
        logic [7:0] b;
        logic       carry_in;
        logic [8:0] wide;
        logic [4:0] nib;
        logic [7:0] r;
        sel_ok    = (int'(sel) < NUM_REGS);
        needs_reg = (cmd == CMD_LOAD_REG) || (cmd == CMD_ACC_FROM_REG) ||
                    (cmd >= CMD_ADD && cmd <= CMD_CMP && !use_op);
        bad       = needs_reg && !sel_ok;
        if (!bad) begin
            a = acc_model;
            b = use_op ? opnd : (sel_ok ? regfile_model[sel] : 8'h00);
            carry_in = flags_model.cy;
            case (cmd)
                CMD_LOAD_REG:     regfile_model[sel] = opnd;
                CMD_LOAD_ACC:     acc_model = opnd;
                CMD_ACC_FROM_REG: acc_model = regfile_model[sel];
                CMD_ADD, CMD_ADC: begin
                    if (cmd == CMD_ADD) carry_in = 1'b0;
                    wide = {1'b0, a} + {1'b0, b} + {8'd0, carry_in};
                    nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_in};
                    r    = wide[7:0];
                    flags_model    = szp_flags(r);
                    flags_model.cy = wide[8];
                    flags_model.ac = nib[4];
                    acc_model      = r;
                end
                CMD_SUB, CMD_SBB, CMD_CMP: begin
                    if (cmd != CMD_SBB) carry_in = 1'b0;
                    // 9-bit difference: bit 8 is the borrow, bit 4 of the nibble too
                    wide = {1'b0, a} - {1'b0, b} - {8'd0, carry_in};
                    nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_in};
                    r    = wide[7:0];
                    flags_model    = szp_flags(r);
                    flags_model.cy = wide[8];
                    flags_model.ac = nib[4];
                    if (cmd != CMD_CMP) acc_model = r;
                end
                CMD_AND, CMD_OR, CMD_XOR: begin
                    r = (cmd == CMD_AND) ? (a & b) : (cmd == CMD_OR) ? (a | b) : (a ^ b);
                    acc_model   = r;
                    flags_model = szp_flags(r);
                end
                CMD_CMC: flags_model.cy = ~flags_model.cy;
                CMD_STC: flags_model.cy = 1'b1;
                default: ;
            endcase
        end
        res.acc       = acc_model;
        res.flags     = flags_model;
        res.reg_value = sel_ok ? regfile_model[sel] : 8'h00;
        res.bad       = bad;
    endtask

    task automatic compare_field(input string fname, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alu_outcome pred;
        t_alu_outcome want;
        if (!i_rst_n) begin
            acc_model   = 8'h00;
            flags_model = '0;
            for (int i = 0; i < 8; i++) regfile_model[i] = 8'h00;
            outcome_q.delete();
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
            bad_reg_results = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_instruction(i_command, i_reg_select, i_use_operand, i_operand, pred);
                outcome_q.push_back(pred);
            end
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("acc_value",    want.acc,           i_acc_value);
                    compare_field("flag_sign",    8'(want.flags.s),   8'(i_flag_sign));
                    compare_field("flag_zero",    8'(want.flags.z),   8'(i_flag_zero));
                    compare_field("flag_aux",     8'(want.flags.ac),  8'(i_flag_aux));
                    compare_field("flag_parity",  8'(want.flags.p),   8'(i_flag_parity));
                    compare_field("flag_carry",   8'(want.flags.cy),  8'(i_flag_carry));
                    compare_field("reg_value",    want.reg_value,     i_reg_value);
                    compare_field("bad_register", 8'(want.bad),       8'(i_bad_register));
                    results_checked++;
                    if (i_bad_register) bad_reg_results++;
                end
            end
            outstanding = outcome_q.size();
        end
    end

endmodule

/* tb/tb_accumulator_alu_with_flags_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_alu_with_flags_unit
// Drives requests into the accumulator ALU: a directed pass over every
// command, flag corner and bad register index, then random traffic under
// three idle/stall mixes plus one long result hold-off. Checking is done
// by aawf_result_checker; this module only stimulates and gives the verdict.
// ----------------------------------------------------------------------------
module tb_accumulator_alu_with_flags_unit import aawf_pkg::*;;

    localparam int NUM_REGS     = 6;
    localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 40;      // long result hold-off for back-pressure
    localparam int DRAIN_CYCLES = 10;      // two-stage pipe, plenty of margin

    // Codes the package does not name
    localparam logic [3:0] CMD_NOP_LOW  = 4'd13;
    localparam logic [3:0] CMD_NOP_HIGH = 4'd15;
    localparam logic [2:0] REG_B        = 3'd0;
    localparam logic [2:0] REG_C        = 3'd1;
    localparam logic [2:0] REG_D        = 3'd2;
    localparam logic [2:0] REG_E        = 3'd3;
    localparam logic [2:0] REG_L        = 3'd5;
    localparam logic [2:0] REG_BAD_LO   = 3'd6;
    localparam logic [2:0] REG_BAD_HI   = 3'd7;
    localparam logic       SRC_REG      = 1'b0;
    localparam logic       SRC_IMM      = 1'b1;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [3:0] i_command      = 4'd0;
    logic [2:0] i_reg_select   = 3'd0;
    logic       i_use_operand  = 1'b0;
    logic [7:0] i_operand      = 8'h00;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_acc_value;
    logic       o_flag_sign;
    logic       o_flag_zero;
    logic       o_flag_aux;
    logic       o_flag_parity;
    logic       o_flag_carry;
    logic [7:0] o_reg_value;
    logic       o_bad_register;

    int mismatches;
    int outstanding;
    int results_checked;
    int bad_reg_results;

    // Idle mix: percent of cycles the sender idles / the receiver stalls
    int in_idle_pct     = 0;
    int out_stall_pct   = 0;
    // Hold-off requests from stimulus vs. hold-offs started by the receiver
    int holds_requested = 0;
    int holds_started   = 0;
    int hold_left       = 0;
    int requests_sent   = 0;
    int cycle_count     = 0;

    always #5 i_clk = ~i_clk;

    accumulator_alu_with_flags_unit #(.NUM_REGS(NUM_REGS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_reg_select   (i_reg_select),
        .i_use_operand  (i_use_operand),
        .i_operand      (i_operand),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_acc_value    (o_acc_value),
        .o_flag_sign    (o_flag_sign),
        .o_flag_zero    (o_flag_zero),
        .o_flag_aux     (o_flag_aux),
        .o_flag_parity  (o_flag_parity),
        .o_flag_carry   (o_flag_carry),
        .o_reg_value    (o_reg_value),
        .o_bad_register (o_bad_register)
    );

    aawf_result_checker #(.NUM_REGS(NUM_REGS)) u_result_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_reg_select      (i_reg_select),
        .i_use_operand     (i_use_operand),
        .i_operand         (i_operand),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_acc_value       (o_acc_value),
        .i_flag_sign       (o_flag_sign),
        .i_flag_zero       (o_flag_zero),
        .i_flag_aux        (o_flag_aux),
        .i_flag_parity     (o_flag_parity),
        .i_flag_carry      (o_flag_carry),
        .i_reg_value       (o_reg_value),
        .i_bad_register    (o_bad_register),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked),
        .o_bad_reg_results (bad_reg_results)
    );

    // Receiver: random stalls at the current mix, or a counted long hold-off
    // when stimulus asks for one. Runs on the falling edge like all drivers.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_started != holds_requested) begin
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES - 1;
            i_out_stall   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one request and hold it until the block takes it. Called and
    // returns at a falling edge; valid is only written once per step, so a
    // back-to-back request keeps valid high without a glitch.
    task automatic send_request(input logic [3:0] cmd, input logic [2:0] sel,
                                input logic use_op, input logic [7:0] opnd);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_reg_select  <= sel;
        i_use_operand <= use_op;
        i_operand     <= opnd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // Random traffic: mostly valid commands on valid registers, with a
    // sprinkling of no-op codes and out-of-range indexes. Operands lean on
    // the byte corners so carries, borrows and zero results come up often.
    task automatic send_random(input int count);
        logic [3:0] cmd;
        logic [2:0] sel;
        logic [7:0] opnd;
        repeat (count) begin
            if ($urandom_range(99) < 8)
                cmd = 4'($urandom_range(CMD_NOP_LOW, CMD_NOP_HIGH));
            else
                cmd = 4'($urandom_range(CMD_LOAD_REG, CMD_STC));
            if ($urandom_range(99) < 10)
                sel = 3'($urandom_range(REG_BAD_LO, REG_BAD_HI));
            else
                sel = 3'($urandom_range(REG_B, REG_L));
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(5))
                    0:       opnd = 8'h00;
                    1:       opnd = 8'hFF;
                    2:       opnd = 8'h80;
                    3:       opnd = 8'h7F;
                    4:       opnd = 8'h0F;
                    default: opnd = 8'h01;
                endcase
            end else begin
                opnd = 8'($urandom_range(255));
            end
            send_request(cmd, sel, 1'($urandom_range(1)), opnd);
        end
    endtask

    initial begin
        // Synchronous reset, released on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed pass: every command, flag corners, bad indexes ----
        send_request(CMD_LOAD_REG,     REG_B,      SRC_IMM, 8'hFF);
        send_request(CMD_LOAD_REG,     REG_C,      SRC_IMM, 8'h01);
        send_request(CMD_LOAD_REG,     REG_D,      SRC_REG, 8'h0F);
        send_request(CMD_LOAD_REG,     REG_L,      SRC_IMM, 8'h80);
        send_request(CMD_LOAD_ACC,     REG_E,      SRC_IMM, 8'h00);
        send_request(CMD_ADD,          REG_B,      SRC_REG, 8'h00);  // 00+FF, sign
        send_request(CMD_ADD,          REG_E,      SRC_IMM, 8'h01);  // wraps to zero, CY, AC
        send_request(CMD_ADC,          REG_C,      SRC_REG, 8'h00);  // carry-in used
        send_request(CMD_SUB,          REG_E,      SRC_IMM, 8'h03);  // borrow out
        send_request(CMD_SBB,          REG_D,      SRC_REG, 8'h00);  // borrow-in used
        send_request(CMD_CMP,          REG_E,      SRC_IMM, 8'hEF);  // equal: Z, acc kept
        send_request(CMD_AND,          REG_E,      SRC_IMM, 8'hF0);
        send_request(CMD_XOR,          REG_E,      SRC_IMM, 8'hFF);
        send_request(CMD_OR,           REG_L,      SRC_REG, 8'h00);
        send_request(CMD_CMC,          REG_E,      SRC_IMM, 8'h00);
        send_request(CMD_CMC,          REG_BAD_LO, SRC_IMM, 8'h00);  // no register needed
        send_request(CMD_STC,          REG_BAD_HI, SRC_REG, 8'h00);
        send_request(CMD_SBB,          REG_E,      SRC_IMM, 8'hFF);  // subtrahend+borrow = 256
        send_request(CMD_ADC,          REG_E,      SRC_IMM, 8'hFF);  // full carry chain
        send_request(CMD_ACC_FROM_REG, REG_L,      SRC_REG, 8'h00);
        // out-of-range index on commands that touch the register: ignored
        send_request(CMD_LOAD_REG,     REG_BAD_LO, SRC_IMM, 8'hA5);
        send_request(CMD_ACC_FROM_REG, REG_BAD_HI, SRC_REG, 8'h00);
        send_request(CMD_ADD,          REG_BAD_LO, SRC_REG, 8'h11);
        // out-of-range index where no register is needed: runs normally
        send_request(CMD_LOAD_ACC,     REG_BAD_HI, SRC_IMM, 8'h7F);
        send_request(CMD_NOP_LOW,      REG_B,      SRC_IMM, 8'hFF);
        send_request(CMD_NOP_HIGH,     REG_BAD_HI, SRC_REG, 8'h00);

        // ---- random: sender idles lightly, receiver stalls heavily ----
        in_idle_pct   = 10;
        out_stall_pct <= 66;
        send_random(600);

        // ---- random: the other way round ----
        in_idle_pct   = 66;
        out_stall_pct <= 10;
        send_random(600);

        // ---- random: no idling on either side ----
        in_idle_pct   = 0;
        out_stall_pct <= 0;
        send_random(250);

        // Long result hold-off while requests keep coming: fills the
        // pipe and forces the block to stall its input.
        holds_requested <= holds_requested + 1;
        send_random(60);
        send_random(290);

        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests: directed corners, then random under three idle/stall mixes",
                 requests_sent);
        $display("and one %0d-cycle result hold-off; %0d results compared, %0d bad-register.",
                 HOLD_CYCLES, results_checked, bad_reg_results);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
